>>> rtl/core/gsrc_pkg.sv
package gsrc_pkg;

	localparam int TIME_BITS = 48;
	localparam int REG_BITS  = 26;
	localparam int WORD_BITS = 16;
	localparam int CRC_BITS  = 8;
	localparam int IDX_BITS  = 8;

	localparam logic [CRC_BITS-1:0] CRC_POLY = 8'h31;
	localparam logic [CRC_BITS-1:0] CRC_INIT = 8'hFF;

	localparam logic [REG_BITS-1:0] MEASURE_INTERVAL_RST = 26'd1000000;
	localparam logic [REG_BITS-1:0] WARMUP_RST           = 26'd15000000;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [REG_BITS-1:0]  reg_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CRC_BITS-1:0]  crc_t;
	typedef logic [IDX_BITS-1:0]  idx_t;

	// register indexes on the configuration port
	localparam idx_t REG_MEASURE_INTERVAL = 8'd0;
	localparam idx_t REG_WARMUP           = 8'd1;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_READ  = 2'd1,
		OP_STOP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_CRC_ERR     = 2'd1,
		ST_NOT_STARTED = 2'd2,
		ST_BUS_FAULT   = 2'd3
	} status_t;

	function automatic crc_t crc_byte(input crc_t crc_in, input logic [7:0] data);
		crc_t c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_BITS-1]) begin
				c = {c[CRC_BITS-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_BITS-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// crc over one word, high byte first
	function automatic crc_t crc_word(input word_t w);
		return crc_byte(crc_byte(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

endpackage

>>> rtl/core/gas_sensor_reading_checker_unit.sv
// gas sensor reading checker: takes start, stop and read requests stamped with a free-running
// microsecond time and returns exactly one result per request. a start powers the unit and
// records its time, a stop drops power and the held sample. a read returns the held sample
// (from_cache set) while it is younger than measure_interval_us; otherwise it checks the
// supplied frame, two 16-bit words each followed by a crc-8 byte (poly 0x31, init 0xff,
// high byte first), and stores it when good. bus fault (status 3) wins over crc mismatch
// (status 1); neither changes state. a read while unpowered gives status 2. the first read
// after start is dated no earlier than start plus measure_interval_us, and warm-up time left
// is clamped at zero. times wrap modulo 2^48. one request is accepted every clock while no
// stalled result blocks the input; a request passes the input register, then the result register,
// and state written by one request is seen by the next, so back-to-back requests run at full rate.
// the only reason to stall is a stalled result: one request may still enter while a result
// waits. configuration is always ready and should be written only while the unit is idle.
module gas_sensor_reading_checker_unit (
	input  logic                   clk,
	input  logic                   arst_n,

	// request channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             operation,
	input  gsrc_pkg::time_t        now_time,
	input  gsrc_pkg::word_t        co2_word,
	input  gsrc_pkg::crc_t         co2_check,
	input  gsrc_pkg::word_t        tvoc_word,
	input  gsrc_pkg::crc_t         tvoc_check,
	input  logic                   bus_fault,

	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output gsrc_pkg::word_t        co2eq_out,
	output gsrc_pkg::word_t        tvoc_out,
	output logic                   warmup_active,
	output logic                   from_cache,
	output gsrc_pkg::reg_t         warmup_left_us,

	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  gsrc_pkg::idx_t         cfg_index,
	input  gsrc_pkg::reg_t         cfg_data
);
	import gsrc_pkg::*;

	// configuration registers
	reg_t measure_interval_q;
	reg_t warmup_q;

	// block state
	logic  powered_q;
	time_t start_time_q;
	time_t sample_time_q;
	word_t held_co2_q;
	word_t held_tvoc_q;
	logic  sample_held_q;

	// input register
	logic       valid_s1;
	logic [1:0] op_s1;
	time_t      now_s1;
	word_t      co2_word_s1;
	crc_t       co2_check_s1;
	word_t      tvoc_word_s1;
	crc_t       tvoc_check_s1;
	logic       fault_s1;

	// result register
	logic    out_valid_q;
	status_t status_q;
	word_t   co2_q;
	word_t   tvoc_q;
	logic    warming_q;
	logic    cached_q;
	reg_t    left_q;

	logic advance;
	logic take_in;

	// stage 1 is retired whenever the result register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign take_in   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign co2eq_out      = co2_q;
	assign tvoc_out       = tvoc_q;
	assign warmup_active  = warming_q;
	assign from_cache     = cached_q;
	assign warmup_left_us = left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_interval_q <= MEASURE_INTERVAL_RST;
			warmup_q           <= WARMUP_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MEASURE_INTERVAL) begin
				measure_interval_q <= cfg_data;
			end else if (cfg_index == REG_WARMUP) begin
				warmup_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1         <= operation;
			now_s1        <= now_time;
			co2_word_s1   <= co2_word;
			co2_check_s1  <= co2_check;
			tvoc_word_s1  <= tvoc_word;
			tvoc_check_s1 <= tvoc_check;
			fault_s1      <= bus_fault;
		end
	end

	// ages are wrapping differences
	time_t   sample_age;
	time_t   start_age;
	time_t   interval_wide;
	time_t   elapsed;
	time_t   first_date;
	logic    is_cached;
	logic    too_early;
	logic    crc_ok;
	logic    in_warmup;

	status_t nx_status;
	word_t   nx_co2;
	word_t   nx_tvoc;
	logic    nx_warming;
	logic    nx_cached;
	reg_t    nx_left;

	logic    do_start;
	logic    do_stop;
	logic    do_store;

	always_comb begin
		interval_wide = time_t'(measure_interval_q);
		sample_age    = now_s1 - sample_time_q;
		start_age     = now_s1 - start_time_q;
		first_date    = start_time_q + interval_wide;
		is_cached     = sample_held_q && (sample_age < interval_wide);
		too_early     = !sample_held_q && (start_age < interval_wide);
		// a first read dated at start plus interval has exactly the interval as its age
		elapsed       = too_early ? interval_wide : start_age;
		in_warmup     = elapsed < time_t'(warmup_q);
		crc_ok        = (crc_word(co2_word_s1) == co2_check_s1)
		             && (crc_word(tvoc_word_s1) == tvoc_check_s1);

		nx_status  = ST_OK;
		nx_co2     = '0;
		nx_tvoc    = '0;
		nx_warming = 1'b0;
		nx_cached  = 1'b0;
		nx_left    = '0;
		do_start   = 1'b0;
		do_stop    = 1'b0;
		do_store   = 1'b0;

		case (op_s1)
			OP_START: begin
				do_start = 1'b1;
			end
			OP_STOP: begin
				do_stop = 1'b1;
			end
			OP_READ: begin
				if (!powered_q) begin
					nx_status = ST_NOT_STARTED;
				end else if (!is_cached && fault_s1) begin
					nx_status = ST_BUS_FAULT;
				end else if (!is_cached && !crc_ok) begin
					nx_status = ST_CRC_ERR;
				end else begin
					do_store   = !is_cached;
					nx_cached  = is_cached;
					nx_co2     = is_cached ? held_co2_q : co2_word_s1;
					nx_tvoc    = is_cached ? held_tvoc_q : tvoc_word_s1;
					nx_warming = in_warmup;
					nx_left    = in_warmup ? (warmup_q - elapsed[REG_BITS-1:0]) : '0;
				end
			end
			default: begin
				// unused code: plain ok result, no change
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powered_q     <= 1'b0;
			start_time_q  <= '0;
			sample_time_q <= '0;
			held_co2_q    <= '0;
			held_tvoc_q   <= '0;
			sample_held_q <= 1'b0;
		end else if (advance) begin
			if (do_start || do_stop) begin
				powered_q     <= do_start;
				start_time_q  <= do_start ? now_s1 : '0;
				sample_time_q <= '0;
				held_co2_q    <= '0;
				held_tvoc_q   <= '0;
				sample_held_q <= 1'b0;
			end else if (do_store) begin
				held_co2_q    <= co2_word_s1;
				held_tvoc_q   <= tvoc_word_s1;
				sample_time_q <= too_early ? first_date : now_s1;
				sample_held_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= nx_status;
			co2_q     <= nx_co2;
			tvoc_q    <= nx_tvoc;
			warming_q <= nx_warming;
			cached_q  <= nx_cached;
			left_q    <= nx_left;
		end
	end

endmodule

>>> test/tb_gas_sensor_reading_checker_unit.sv
module tb_gas_sensor_reading_checker_unit;
	import gsrc_pkg::*;

	// operation code with no meaning, the unit must treat it as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// largest register setting in use
	localparam reg_t SETTING_MAX = 26'd60000000;
	// cycles in a row with no handshake on any channel before giving up
	localparam int QUIET_LIMIT = 1000;

	// one request as it travels on the input channel
	typedef struct {
		logic [1:0] op;
		time_t      now;
		word_t      co2;
		crc_t       co2_crc;
		word_t      tvoc;
		crc_t       tvoc_crc;
		logic       fault;
	} sensor_request_t;

	// one reading as the unit should report it
	typedef struct {
		status_t status;
		word_t   co2;
		word_t   tvoc;
		logic    warm;
		logic    cached;
		reg_t    left;
	} reading_t;

	// ways a read frame can be damaged
	typedef enum {
		FRAME_GOOD,
		FRAME_BAD_CO2,
		FRAME_BAD_TVOC,
		FRAME_BUS_FAULT,
		FRAME_BUS_FAULT_BAD_CRC
	} frame_kind_t;

	logic clk;
	logic arst_n = 1'b0;

	// request channel, all driven to known values from time zero
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [1:0] operation  = OP_START;
	time_t      now_time   = '0;
	word_t      co2_word   = '0;
	crc_t       co2_check  = '0;
	word_t      tvoc_word  = '0;
	crc_t       tvoc_check = '0;
	logic       bus_fault  = 1'b0;

	// result channel
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	word_t      co2eq_out;
	word_t      tvoc_out;
	logic       warmup_active;
	logic       from_cache;
	reg_t       warmup_left_us;

	// configuration channel
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	idx_t       cfg_index = REG_MEASURE_INTERVAL;
	reg_t       cfg_data  = '0;

	// idling rates in percent, changed per phase
	int tx_idle_pct  = 6;
	int rx_stall_pct = 59;

	// expected readings, oldest first
	reading_t readings_due[$];

	int unsigned requests_sent    = 0;
	int unsigned readings_checked = 0;
	int unsigned settings_count   = 1;
	int unsigned mismatch_count   = 0;
	int unsigned quiet_cycles     = 0;

	// predictor copy of the registers and the sensor state
	reg_t  interval_us   = MEASURE_INTERVAL_RST;
	reg_t  warmup_len_us = WARMUP_RST;
	logic  pwr_on        = 1'b0;
	time_t t_start       = '0;
	time_t t_sample      = '0;
	word_t co2_held      = '0;
	word_t tvoc_held     = '0;
	logic  have_sample   = 1'b0;

	gas_sensor_reading_checker_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.now_time       (now_time),
		.co2_word       (co2_word),
		.co2_check      (co2_check),
		.tvoc_word      (tvoc_word),
		.tvoc_check     (tvoc_check),
		.bus_fault      (bus_fault),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.co2eq_out      (co2eq_out),
		.tvoc_out       (tvoc_out),
		.warmup_active  (warmup_active),
		.from_cache     (from_cache),
		.warmup_left_us (warmup_left_us),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// crc-8 over one word, bit serial, msb first
	function automatic crc_t frame_crc(input word_t w);
		crc_t c;
		c = CRC_INIT;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (c[CRC_BITS-1] ^ w[b]) begin
				c = {c[CRC_BITS-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_BITS-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// start and stop both drop whatever sample was held
	function automatic void forget_sample();
		t_start     = '0;
		t_sample    = '0;
		co2_held    = '0;
		tvoc_held   = '0;
		have_sample = 1'b0;
	endfunction

	// advance the predictor by one request and give the reading it should produce
	task automatic predict_reading(input sensor_request_t r, output reading_t e);
		time_t stamp;
		time_t age;
		e.status = ST_OK;
		e.co2    = '0;
		e.tvoc   = '0;
		e.warm   = 1'b0;
		e.cached = 1'b0;
		e.left   = '0;
		case (r.op)
			OP_START: begin
				forget_sample();
				pwr_on  = 1'b1;
				t_start = r.now;
			end
			OP_STOP: begin
				pwr_on = 1'b0;
				forget_sample();
			end
			OP_READ: begin
				if (!pwr_on) begin
					e.status = ST_NOT_STARTED;
				end else begin
					stamp = r.now;
					// ages are wrapping differences in the time width
					age = r.now - t_sample;
					if (have_sample && age < interval_us) begin
						e.cached = 1'b1;
					end else begin
						age = r.now - t_start;
						// first read is never dated before start plus the interval
						if (!have_sample && age < interval_us) begin
							stamp = t_start + interval_us;
						end
						if (r.fault) begin
							e.status = ST_BUS_FAULT;
						end else if (frame_crc(r.co2) != r.co2_crc
								|| frame_crc(r.tvoc) != r.tvoc_crc) begin
							e.status = ST_CRC_ERR;
						end else begin
							co2_held    = r.co2;
							tvoc_held   = r.tvoc;
							t_sample    = stamp;
							have_sample = 1'b1;
						end
					end
					if (e.status == ST_OK) begin
						age    = stamp - t_start;
						e.co2  = co2_held;
						e.tvoc = tvoc_held;
						if (age < warmup_len_us) begin
							e.warm = 1'b1;
							e.left = warmup_len_us - reg_t'(age);
						end
					end
				end
			end
			default: begin
				// unused code leaves everything alone
			end
		endcase
	endtask

	// read request with a frame built to the given kind
	function automatic sensor_request_t read_req(input time_t now, input word_t co2,
			input word_t tvoc, input frame_kind_t kind);
		sensor_request_t r;
		r.op       = OP_READ;
		r.now      = now;
		r.co2      = co2;
		r.tvoc     = tvoc;
		r.co2_crc  = frame_crc(co2);
		r.tvoc_crc = frame_crc(tvoc);
		r.fault    = 1'b0;
		case (kind)
			FRAME_BAD_CO2: r.co2_crc = r.co2_crc ^ crc_t'($urandom_range(255, 1));
			FRAME_BAD_TVOC: r.tvoc_crc = r.tvoc_crc ^ crc_t'($urandom_range(255, 1));
			FRAME_BUS_FAULT: r.fault = 1'b1;
			FRAME_BUS_FAULT_BAD_CRC: begin
				r.fault   = 1'b1;
				r.co2_crc = r.co2_crc ^ crc_t'($urandom_range(255, 1));
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// start, stop or unused request; frame fields are noise
	function automatic sensor_request_t plain_req(input logic [1:0] op, input time_t now);
		sensor_request_t r;
		r.op       = op;
		r.now      = now;
		r.co2      = word_t'($urandom);
		r.co2_crc  = crc_t'($urandom);
		r.tvoc     = word_t'($urandom);
		r.tvoc_crc = crc_t'($urandom);
		r.fault    = 1'($urandom_range(1));
		return r;
	endfunction

	// drive one request and hold it until accepted; entered and left at a falling edge
	task automatic send_request(input sensor_request_t r);
		reading_t e;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= r.op;
		now_time   <= r.now;
		co2_word   <= r.co2;
		co2_check  <= r.co2_crc;
		tvoc_word  <= r.tvoc;
		tvoc_check <= r.tvoc_crc;
		bus_fault  <= r.fault;
		do @(posedge clk); while (in_stall);
		predict_reading(r, e);
		readings_due.push_back(e);
		requests_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait for every outstanding reading
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (readings_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// write both registers back to back; only called while the unit is idle
	task automatic write_settings(input reg_t interval, input reg_t warmup);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MEASURE_INTERVAL;
		cfg_data  <= interval;
		do @(posedge clk); while (!cfg_ready);
		interval_us = interval;
		@(negedge clk);
		cfg_index <= REG_WARMUP;
		cfg_data  <= warmup;
		do @(posedge clk); while (!cfg_ready);
		warmup_len_us = warmup;
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// step between reads, scaled to the current settings so caching and warm-up both show
	function automatic time_t time_step();
		case ($urandom_range(9))
			0, 1, 2, 3: return time_t'($urandom_range(interval_us));
			4: return (interval_us == 0) ? time_t'(0) : time_t'(interval_us - 1'b1);
			5: return time_t'(interval_us);
			6: return time_t'($urandom_range(warmup_len_us));
			7: return time_t'(warmup_len_us) + time_t'($urandom_range(2));
			// far jump, may land before the start time
			8: return time_t'({$urandom, $urandom});
			default: return time_t'($urandom_range(20));
		endcase
	endfunction

	// start time, sometimes just short of the wrap point
	function automatic time_t start_stamp();
		if ($urandom_range(5) == 0) begin
			return '1 - time_t'($urandom_range(2 * interval_us + 10));
		end
		return time_t'({$urandom, $urandom});
	endfunction

	function automatic frame_kind_t frame_pick();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 75) return FRAME_GOOD;
		if (p < 85) return FRAME_BAD_CO2;
		if (p < 92) return FRAME_BAD_TVOC;
		if (p < 97) return FRAME_BUS_FAULT;
		return FRAME_BUS_FAULT_BAD_CRC;
	endfunction

	// reads, stops and junk before any start
	task automatic test_unpowered_requests();
		send_request(read_req(48'd1000, 16'h1234, 16'h5678, FRAME_GOOD));
		send_request(plain_req(OP_UNUSED, 48'd5));
		send_request(plain_req(OP_STOP, 48'd7));
		send_request(read_req(48'd9, 16'hBEEF, 16'h0001, FRAME_BUS_FAULT));
	endtask

	// first read dated at start plus interval, cached reads, fresh reads, end of warm-up
	task automatic test_first_read_and_cache();
		send_request(plain_req(OP_START, 48'd1000));
		send_request(read_req(48'd1000, 16'd400, 16'd0, FRAME_GOOD));
		send_request(read_req(48'd1001010, 16'd999, 16'd999, FRAME_GOOD));
		send_request(read_req(48'd2001000, 16'd410, 16'd12, FRAME_GOOD));
		send_request(read_req(48'd16001000, 16'd420, 16'd15, FRAME_GOOD));
		send_request(read_req(48'd16001001, 16'd1, 16'd1, FRAME_BAD_CO2));
		send_request(plain_req(OP_STOP, 48'd16001002));
	endtask

	// crc and bus fault handling, fault wins over crc, extreme words
	task automatic test_frame_checks();
		send_request(plain_req(OP_START, 48'd0));
		send_request(read_req(48'd2000000, 16'hA5A5, 16'h5A5A, FRAME_BAD_CO2));
		send_request(read_req(48'd2000000, 16'hA5A5, 16'h5A5A, FRAME_BAD_TVOC));
		send_request(read_req(48'd2000000, 16'hA5A5, 16'h5A5A, FRAME_BUS_FAULT));
		send_request(read_req(48'd2000000, 16'hA5A5, 16'h5A5A, FRAME_BUS_FAULT_BAD_CRC));
		send_request(read_req(48'd2000000, 16'h0000, 16'hFFFF, FRAME_GOOD));
		send_request(read_req(48'd4000000, 16'hFFFF, 16'h0000, FRAME_GOOD));
	endtask

	// start just before the time wraps, and a read dated before its start
	task automatic test_time_wrap();
		send_request(plain_req(OP_START, '1 - time_t'(20)));
		send_request(read_req('1, 16'h8001, 16'h7FFE, FRAME_GOOD));
		send_request(read_req(48'd30, 16'h0F0F, 16'hF0F0, FRAME_GOOD));
		send_request(plain_req(OP_START, 48'd1000));
		send_request(read_req(48'd10, 16'h3C3C, 16'hC3C3, FRAME_GOOD));
	endtask

	// sessions of start, reads with moving time, occasional stops and junk
	task automatic test_random_traffic(input reg_t interval, input reg_t warmup,
			input int tx_pct, input int rx_pct, input int count);
		time_t clock_us;
		int unsigned pick;
		settle();
		write_settings(interval, warmup);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		clock_us = start_stamp();
		send_request(plain_req(OP_START, clock_us));
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				send_request(plain_req(OP_STOP, clock_us));
			end else if (pick < 7) begin
				clock_us = start_stamp();
				send_request(plain_req(OP_START, clock_us));
			end else if (pick < 9) begin
				send_request(plain_req(OP_UNUSED, clock_us));
			end else begin
				clock_us = clock_us + time_step();
				send_request(read_req(clock_us, word_t'($urandom), word_t'($urandom),
					frame_pick()));
			end
		end
	endtask

	// receiver stall, new draw every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// compare each accepted reading against the oldest one due
	always @(posedge clk) begin : check_reading
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) begin
				$error("reading with no request outstanding, status %0d", status);
				mismatch_count++;
			end else begin
				want = readings_due.pop_front();
				check_field("status", want.status, status);
				check_field("co2eq_out", want.co2, co2eq_out);
				check_field("tvoc_out", want.tvoc, tvoc_out);
				check_field("warmup_active", want.warm, warmup_active);
				check_field("from_cache", want.cached, from_cache);
				check_field("warmup_left_us", want.left, warmup_left_us);
				readings_checked++;
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout with %0d readings outstanding", readings_due.size());
			$display("gas_sensor_reading_checker_unit: mismatch");
			$finish;
		end
	end

	initial begin
		// hold reset, then release it on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part runs on the reset settings
		test_unpowered_requests();
		test_first_read_and_cache();
		test_frame_checks();
		test_time_wrap();

		// no caching at all, longest warm-up; sender rarely idle, receiver often stalled
		test_random_traffic(26'd0, SETTING_MAX, 6, 59, 220);
		// longest interval, no warm-up; sender often idle, receiver rarely stalled
		test_random_traffic(SETTING_MAX, 26'd0, 59, 6, 220);
		// short settings so caching and warm-up flip often; full rate
		test_random_traffic(26'd700, 26'd5000, 0, 0, 220);

		settle();
		// let any stray reading show up
		repeat (4) @(posedge clk);

		$display("covered %0d requests and %0d readings over %0d register settings",
			requests_sent, readings_checked, settings_count);
		$display("start, stop, read, unused code, crc and bus faults, time wrap, idling");
		if (mismatch_count == 0) begin
			$display("gas_sensor_reading_checker_unit: match");
		end else begin
			$display("gas_sensor_reading_checker_unit: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/gsrc_pkg.sv
rtl/core/gas_sensor_reading_checker_unit.sv
test/tb_gas_sensor_reading_checker_unit.sv
